FILE: src/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared codes, result types and helper functions for the JSON string
// unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// operation codes of a request
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	// decoder modes
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_BODY = 2'd1;
	localparam logic [1:0] MODE_ESC  = 2'd2;
	localparam logic [1:0] MODE_HEX  = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_CONTROL = 3'd1;
	localparam logic [2:0] ERR_UNTERM  = 3'd2;
	localparam logic [2:0] ERR_ESC_END = 3'd3;
	localparam logic [2:0] ERR_UNKNOWN = 3'd4;
	localparam logic [2:0] ERR_BAD_HEX = 3'd5;
	localparam logic [2:0] ERR_SHORT_U = 3'd6;

	// characters of interest
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U = 8'h75;

	// utf-8 encoding limits and marks
	localparam logic [15:0] UTF8_MAX1 = 16'h007F;
	localparam logic [15:0] UTF8_MAX2 = 16'h07FF;
	localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF8_CONT  = 8'h80;

	localparam int MAX_RESULTS = 3;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic [2:0] error_code;
	} result_t;

	// group of results caused by one request
	typedef struct packed {
		logic               valid;
		logic [1:0]         cnt;
		result_t [MAX_RESULTS-1:0] res;
	} group_t;

	// hex digit value, msb flags a valid digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			v = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			v = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			v = {1'b1, 4'(c - 8'h37)};
		return v;
	endfunction

	// single-byte escape map, msb flags a known escape
	function automatic logic [8:0] esc_map(input logic [7:0] c);
		logic [8:0] m;
		case (c)
			8'h22:   m = {1'b1, 8'h22};
			8'h5C:   m = {1'b1, 8'h5C};
			8'h2F:   m = {1'b1, 8'h2F};
			8'h62:   m = {1'b1, 8'h08};
			8'h66:   m = {1'b1, 8'h0C};
			8'h6E:   m = {1'b1, 8'h0A};
			8'h72:   m = {1'b1, 8'h0D};
			8'h74:   m = {1'b1, 8'h09};
			default: m = 9'd0;
		endcase
		return m;
	endfunction

	function automatic result_t mk_result(input logic [7:0] b, input logic [1:0] k,
			input logic [2:0] e);
		result_t r;
		r.out_byte   = b;
		r.kind       = k;
		r.error_code = e;
		return r;
	endfunction

endpackage

FILE: src/jsu_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_item_if
// Request channel of the unescaper: operation and raw string byte.
// ----------------------------------------------------------------------------
interface jsu_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] data_byte;

	modport source (output valid, operation, data_byte, input ready);
	modport sink (input valid, operation, data_byte, output ready);
endinterface

FILE: src/jsu_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_result_if
// Result channel of the unescaper: decoded byte, kind, error code and last.
// ----------------------------------------------------------------------------
interface jsu_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic [2:0] error_code;
	logic       last;

	modport source (output valid, out_byte, kind, error_code, last, input ready);
	modport sink (input valid, out_byte, kind, error_code, last, output ready);
endinterface

FILE: src/jsu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode
// Input register, decoder state and the single-pass decode of one request
// into a group of up to three results.
// ----------------------------------------------------------------------------
module jsu_decode (
	input  logic           clk,
	input  logic           arst_n,
	jsu_item_if.sink       item,
	input  logic           room,
	output jsu_pkg::group_t grp
);
	import jsu_pkg::*;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [7:0]  byte_s1;

	logic [1:0]  mode_q;
	logic [1:0]  hex_q;
	logic [15:0] cp_q;

	logic [1:0]  mode_d;
	logic [1:0]  hex_d;
	logic [15:0] cp_d;
	logic [1:0]  cnt_d;
	result_t [MAX_RESULTS-1:0] res_d;

	logic        commit;
	logic        take;
	logic [4:0]  hv;
	logic [8:0]  em;
	logic [15:0] cp_new;
	logic        ctrl;

	assign hv     = hex_value(byte_s1);
	assign em     = esc_map(byte_s1);
	assign cp_new = {cp_q[11:0], hv[3:0]};
	assign ctrl   = (byte_s1[7:5] == 3'd0);

	// request commits once the result register has room, or at once if it gives no results
	assign commit     = valid_s1 && ((cnt_d == 2'd0) || room);
	assign item.ready = !valid_s1 || commit;
	assign take       = item.valid && item.ready;

	// decode of the held request
	always_comb begin
		mode_d = mode_q;
		hex_d  = hex_q;
		cp_d   = cp_q;
		cnt_d  = 2'd0;
		for (int i = 0; i < MAX_RESULTS; i++)
			res_d[i] = mk_result(8'd0, KIND_BYTE, ERR_NONE);
		case (op_s1)
			OP_START: begin
				mode_d = MODE_BODY;
				hex_d  = 2'd0;
				cp_d   = 16'd0;
			end
			OP_BYTE: begin
				case (mode_q)
					MODE_BODY: begin
						if (byte_s1 == CH_QUOTE) begin
							mode_d   = MODE_IDLE;
							cnt_d    = 2'd1;
							res_d[0] = mk_result(8'd0, KIND_CLOSE, ERR_NONE);
						end else if (byte_s1 == CH_BSLASH) begin
							mode_d = MODE_ESC;
						end else if (ctrl) begin
							mode_d   = MODE_IDLE;
							hex_d    = 2'd0;
							cp_d     = 16'd0;
							cnt_d    = 2'd1;
							res_d[0] = mk_result(8'd0, KIND_ERROR, ERR_CONTROL);
						end else begin
							cnt_d    = 2'd1;
							res_d[0] = mk_result(byte_s1, KIND_BYTE, ERR_NONE);
						end
					end
					MODE_ESC: begin
						if (byte_s1 == CH_U) begin
							mode_d = MODE_HEX;
							hex_d  = 2'd0;
							cp_d   = 16'd0;
						end else if (em[8]) begin
							mode_d   = MODE_BODY;
							cnt_d    = 2'd1;
							res_d[0] = mk_result(em[7:0], KIND_BYTE, ERR_NONE);
						end else begin
							mode_d   = MODE_IDLE;
							hex_d    = 2'd0;
							cp_d     = 16'd0;
							cnt_d    = 2'd1;
							res_d[0] = mk_result(8'd0, KIND_ERROR, ERR_UNKNOWN);
						end
					end
					MODE_HEX: begin
						if (byte_s1 == CH_QUOTE || ctrl || !hv[4]) begin
							mode_d = MODE_IDLE;
							hex_d  = 2'd0;
							cp_d   = 16'd0;
							cnt_d  = 2'd1;
							if (byte_s1 == CH_QUOTE)
								res_d[0] = mk_result(8'd0, KIND_ERROR, ERR_SHORT_U);
							else if (ctrl)
								res_d[0] = mk_result(8'd0, KIND_ERROR, ERR_CONTROL);
							else
								res_d[0] = mk_result(8'd0, KIND_ERROR, ERR_BAD_HEX);
						end else if (hex_q == 2'd3) begin
							// fourth digit: utf-8 encode the code point
							mode_d = MODE_BODY;
							hex_d  = 2'd0;
							cp_d   = 16'd0;
							if (cp_new <= UTF8_MAX1) begin
								cnt_d    = 2'd1;
								res_d[0] = mk_result(cp_new[7:0], KIND_BYTE, ERR_NONE);
							end else if (cp_new <= UTF8_MAX2) begin
								cnt_d    = 2'd2;
								res_d[0] = mk_result(UTF8_LEAD2 | {3'd0, cp_new[10:6]},
									KIND_BYTE, ERR_NONE);
								res_d[1] = mk_result(UTF8_CONT | {2'd0, cp_new[5:0]},
									KIND_BYTE, ERR_NONE);
							end else begin
								cnt_d    = 2'd3;
								res_d[0] = mk_result(UTF8_LEAD3 | {4'd0, cp_new[15:12]},
									KIND_BYTE, ERR_NONE);
								res_d[1] = mk_result(UTF8_CONT | {2'd0, cp_new[11:6]},
									KIND_BYTE, ERR_NONE);
								res_d[2] = mk_result(UTF8_CONT | {2'd0, cp_new[5:0]},
									KIND_BYTE, ERR_NONE);
							end
						end else begin
							hex_d = hex_q + 2'd1;
							cp_d  = cp_new;
						end
					end
					default: begin
					end
				endcase
			end
			OP_END: begin
				if (mode_q == MODE_BODY || mode_q == MODE_HEX || mode_q == MODE_ESC) begin
					mode_d   = MODE_IDLE;
					hex_d    = 2'd0;
					cp_d     = 16'd0;
					cnt_d    = 2'd1;
					res_d[0] = mk_result(8'd0, KIND_ERROR,
						(mode_q == MODE_ESC) ? ERR_ESC_END : ERR_UNTERM);
				end
			end
			default: begin
			end
		endcase
	end

	assign grp.valid = commit && (cnt_d != 2'd0);
	assign grp.cnt   = cnt_d;
	assign grp.res   = res_d;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1   <= item.operation;
			byte_s1 <= item.data_byte;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			hex_q  <= 2'd0;
			cp_q   <= 16'd0;
		end else if (commit) begin
			mode_q <= mode_d;
			hex_q  <= hex_d;
			cp_q   <= cp_d;
		end
	end

endmodule

FILE: src/jsu_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_emit
// Result register holding one group of results and handing them out one per
// cycle while the result side is ready, marking the final one of the group.
// ----------------------------------------------------------------------------
module jsu_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  jsu_pkg::group_t grp,
	output logic            room,
	jsu_result_if.source    result
);
	import jsu_pkg::*;

	result_t [MAX_RESULTS-1:0] res_q;
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	result_t    cur;
	logic       fire;
	logic       at_last;

	// pick the current result
	always_comb begin
		case (idx_q)
			2'd0:    cur = res_q[0];
			2'd1:    cur = res_q[1];
			default: cur = res_q[2];
		endcase
	end

	assign at_last = (idx_q == (cnt_q - 2'd1));
	assign fire    = result.valid && result.ready;
	assign room    = (cnt_q == 2'd0) || (fire && at_last);

	assign result.valid      = (cnt_q != 2'd0);
	assign result.out_byte   = cur.out_byte;
	assign result.kind       = cur.kind;
	assign result.error_code = cur.error_code;
	assign result.last       = at_last;

	// group count and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (grp.valid) begin
			cnt_q <= grp.cnt;
			idx_q <= 2'd0;
		end else if (fire) begin
			if (at_last) begin
				cnt_q <= 2'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// group payload
	always_ff @(posedge clk) begin
		if (grp.valid)
			res_q <= grp.res;
	end

endmodule

FILE: src/json_string_unescape_utf8_core.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle while each gives at most one result and
// the result side is ready; a request giving n results holds the result
// register until all n are handed out. The result register path (one result
// handed out per cycle while the result side is ready) sets the rate.
// Reset: asynchronous, clears the decoder to idle and empties both registers.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// JSON string body unescaper with \u to UTF-8 encoding, one byte a request.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core (
	input  logic         clk,
	input  logic         arst_n,
	jsu_item_if.sink     item,
	jsu_result_if.source result
);
	import jsu_pkg::*;

	group_t grp;
	logic   room;

	// decode stage
	jsu_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.room   (room),
		.grp    (grp)
	);

	// result register
	jsu_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.grp    (grp),
		.room   (room),
		.result (result)
	);

endmodule

FILE: test/json_string_unescape_utf8_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core_tb
// Drives byte-wise JSON string bodies into the unescaper and compares every
// result against a cycle-free decoder kept alongside. The run has directed
// tests for plain bytes, escapes, unicode and errors, then random strings.
// Both handshakes see random gaps, with one long output hold-off.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core_tb;
	import jsu_pkg::*;

	localparam logic [7:0] CTRL_LIMIT = 8'h20;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam int         LONG_HOLD  = 60;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic [2:0] error_code;
		logic       last;
	} decoded_t;

	logic clk = 1'b0;
	logic arst_n;

	jsu_item_if   item_ch ();
	jsu_result_if result_ch ();

	json_string_unescape_utf8_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// decoder state mirrored from the block
	logic [1:0]  dec_mode;
	logic [1:0]  digits_taken;
	logic [15:0] gathered_cp;

	decoded_t decoded_group[$];
	decoded_t expected_results[$];
	decoded_t head_exp;

	int  mismatches   = 0;
	int  items_sent   = 0;
	int  holds_asked  = 0;
	int  holds_served = 0;
	bit  src_idle_on  = 1'b0;
	bit  snk_stall_on = 1'b0;

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hex digit test shared by stimulus and decoder
	function automatic bit hex_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	// letters of the single-byte escapes
	function automatic logic [7:0] simple_escape(input int idx);
		case (idx)
			0:       return CH_QUOTE;
			1:       return CH_BSLASH;
			2:       return CH_SLASH;
			3:       return "b";
			4:       return "f";
			5:       return "n";
			6:       return "r";
			default: return "t";
		endcase
	endfunction

	function automatic void add_result(input logic [7:0] b, input logic [1:0] k,
			input logic [2:0] e);
		decoded_t r;
		r.out_byte   = b;
		r.kind       = k;
		r.error_code = e;
		r.last       = 1'b0;
		decoded_group.push_back(r);
	endfunction

	function automatic void raise_error(input logic [2:0] e);
		dec_mode     = MODE_IDLE;
		digits_taken = 2'd0;
		gathered_cp  = 16'd0;
		add_result(8'h00, KIND_ERROR, e);
	endfunction

	// decode one request, queue its results; returns 0 when the block ignores it
	function automatic bit decode_request(input logic [1:0] op, input logic [7:0] c);
		logic [8:0]  esc;
		logic [3:0]  nib;
		logic [15:0] v;
		bit          acted;
		acted = 1'b1;
		decoded_group.delete();
		case (op)
			OP_START: begin
				dec_mode     = MODE_BODY;
				digits_taken = 2'd0;
				gathered_cp  = 16'd0;
			end
			OP_BYTE: begin
				case (dec_mode)
					MODE_BODY: begin
						if (c == CH_QUOTE) begin
							dec_mode = MODE_IDLE;
							add_result(8'h00, KIND_CLOSE, ERR_NONE);
						end else if (c == CH_BSLASH)
							dec_mode = MODE_ESC;
						else if (c < CTRL_LIMIT)
							raise_error(ERR_CONTROL);
						else
							add_result(c, KIND_BYTE, ERR_NONE);
					end
					MODE_ESC: begin
						case (c)
							CH_QUOTE, CH_BSLASH, CH_SLASH: esc = {1'b1, c};
							"b":     esc = {1'b1, 8'h08};
							"f":     esc = {1'b1, 8'h0C};
							"n":     esc = {1'b1, 8'h0A};
							"r":     esc = {1'b1, 8'h0D};
							"t":     esc = {1'b1, 8'h09};
							default: esc = 9'd0;
						endcase
						if (c == CH_U) begin
							dec_mode     = MODE_HEX;
							digits_taken = 2'd0;
							gathered_cp  = 16'd0;
						end else if (esc[8]) begin
							dec_mode = MODE_BODY;
							add_result(esc[7:0], KIND_BYTE, ERR_NONE);
						end else
							raise_error(ERR_UNKNOWN);
					end
					MODE_HEX: begin
						nib = (c >= "0" && c <= "9") ? c[3:0] : c[3:0] + 4'd9;
						if (c == CH_QUOTE)
							raise_error(ERR_SHORT_U);
						else if (c < CTRL_LIMIT)
							raise_error(ERR_CONTROL);
						else if (!hex_char(c))
							raise_error(ERR_BAD_HEX);
						else if (digits_taken == 2'd3) begin
							// fourth digit: encode the code point as utf-8
							v = {gathered_cp[11:0], nib};
							if (v <= UTF8_MAX1)
								add_result(v[7:0], KIND_BYTE, ERR_NONE);
							else if (v <= UTF8_MAX2) begin
								add_result(UTF8_LEAD2 | {3'b0, v[10:6]}, KIND_BYTE, ERR_NONE);
								add_result(UTF8_CONT | {2'b0, v[5:0]}, KIND_BYTE, ERR_NONE);
							end else begin
								add_result(UTF8_LEAD3 | {4'b0, v[15:12]}, KIND_BYTE, ERR_NONE);
								add_result(UTF8_CONT | {2'b0, v[11:6]}, KIND_BYTE, ERR_NONE);
								add_result(UTF8_CONT | {2'b0, v[5:0]}, KIND_BYTE, ERR_NONE);
							end
							dec_mode     = MODE_BODY;
							digits_taken = 2'd0;
							gathered_cp  = 16'd0;
						end else begin
							gathered_cp  = {gathered_cp[11:0], nib};
							digits_taken = digits_taken + 2'd1;
						end
					end
					default: acted = 1'b0;
				endcase
			end
			OP_END: begin
				if (dec_mode == MODE_BODY || dec_mode == MODE_HEX)
					raise_error(ERR_UNTERM);
				else if (dec_mode == MODE_ESC)
					raise_error(ERR_ESC_END);
				else
					acted = 1'b0;
			end
			default: acted = 1'b0;
		endcase
		// mark the final result of the request
		if (decoded_group.size() > 0)
			decoded_group[decoded_group.size() - 1].last = 1'b1;
		foreach (decoded_group[i])
			expected_results.push_back(decoded_group[i]);
		return acted;
	endfunction

	// send one request, with an optional idle burst in front
	task automatic send_request(input logic [1:0] op, input logic [7:0] b);
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.operation <= op;
		item_ch.data_byte <= b;
		do
			@(posedge clk);
		while (item_ch.ready !== 1'b1);
		void'(decode_request(op, b));
		items_sent++;
	endtask

	task automatic send_hex_digit(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < 4'd10)
			ch = "0" + nib;
		else
			ch = ($urandom_range(0, 1) ? "a" : "A") + nib - 8'd10;
		send_request(OP_BYTE, ch);
	endtask

	task automatic send_unicode(input logic [15:0] v);
		send_request(OP_BYTE, CH_BSLASH);
		send_request(OP_BYTE, CH_U);
		send_hex_digit(v[15:12]);
		send_hex_digit(v[11:8]);
		send_hex_digit(v[7:4]);
		send_hex_digit(v[3:0]);
	endtask

	// compare one field of a result
	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: expected no result, got byte %0h kind %0d error %0d last %0b",
					$time, result_ch.out_byte, result_ch.kind, result_ch.error_code,
					result_ch.last);
			end else begin
				head_exp = expected_results.pop_front();
				check_field("out_byte", head_exp.out_byte, result_ch.out_byte);
				check_field("kind", 8'(head_exp.kind), 8'(result_ch.kind));
				check_field("error_code", 8'(head_exp.error_code),
					8'(result_ch.error_code));
				check_field("last", 8'(head_exp.last), 8'(result_ch.last));
			end
		end
	end

	// result side ready: random stalls and the long hold-off on request
	initial begin : result_sink
		int gap;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holds_served != holds_asked) begin
				holds_served++;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				result_ch.ready <= 1'b1;
			end else if (snk_stall_on && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 4);
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				result_ch.ready <= 1'b1;
			end else
				result_ch.ready <= 1'b1;
		end
	end

	// plain byte extremes and a normal close
	task automatic test_plain_and_close();
		send_request(OP_START, 8'hFF);
		send_request(OP_BYTE, CTRL_LIMIT);
		send_request(OP_BYTE, 8'hFF);
		send_request(OP_BYTE, CH_QUOTE);
	endtask

	// escape mapping and the escape errors
	task automatic test_escapes();
		send_request(OP_START, 8'h00);
		send_request(OP_BYTE, CH_BSLASH);
		send_request(OP_BYTE, "n");
		send_request(OP_BYTE, 8'h1F);
		send_request(OP_START, 8'h00);
		send_request(OP_BYTE, CH_BSLASH);
		send_request(OP_END, 8'h00);
		send_request(OP_START, 8'h00);
		send_request(OP_BYTE, CH_BSLASH);
		send_request(OP_BYTE, 8'h00);
	endtask

	// \u0000, the widest code point, and end of input mid-string
	task automatic test_unicode();
		send_request(OP_START, 8'h00);
		send_unicode(16'h0000);
		send_unicode(16'hFFFF);
		send_request(OP_END, 8'hFF);
		// quote and backslash among the digits
		send_request(OP_START, 8'h00);
		send_request(OP_BYTE, CH_BSLASH);
		send_request(OP_BYTE, CH_U);
		send_request(OP_BYTE, "1");
		send_request(OP_BYTE, CH_QUOTE);
		send_request(OP_START, 8'h00);
		send_request(OP_BYTE, CH_BSLASH);
		send_request(OP_BYTE, CH_U);
		send_request(OP_BYTE, CH_BSLASH);
	endtask

	// requests while idle, operation 3, and a start dropping a string mid-escape
	task automatic test_ignored_and_restart();
		send_request(2'd3, 8'hFF);
		send_request(OP_BYTE, "A");
		send_request(OP_END, 8'h00);
		send_request(OP_START, 8'h00);
		send_request(OP_BYTE, CH_BSLASH);
		send_request(OP_BYTE, CH_U);
		send_request(OP_BYTE, "7");
		send_request(OP_START, 8'h00);
		send_request(2'd3, 8'h55);
		send_request(OP_BYTE, "A");
		send_request(OP_BYTE, CH_QUOTE);
	endtask

	// a malformed ending: the block goes idle after it
	task automatic send_broken_tail();
		logic [7:0] ch;
		bit         known;
		int         k;
		case ($urandom_range(0, 4))
			0: send_request(OP_BYTE, 8'($urandom_range(0, 31)));
			1: begin
				send_request(OP_BYTE, CH_BSLASH);
				do begin
					ch = 8'($urandom_range(0, 255));
					known = (ch == CH_U);
					for (k = 0; k < 8; k++)
						if (ch == simple_escape(k))
							known = 1'b1;
				end while (known);
				send_request(OP_BYTE, ch);
			end
			2: begin
				send_request(OP_BYTE, CH_BSLASH);
				send_request(OP_END, 8'($urandom_range(0, 255)));
			end
			3: begin
				send_request(OP_BYTE, CH_BSLASH);
				send_request(OP_BYTE, CH_U);
				for (k = $urandom_range(0, 3); k > 0; k--)
					send_hex_digit(4'($urandom_range(0, 15)));
				case ($urandom_range(0, 3))
					0: send_request(OP_BYTE, CH_QUOTE);
					1: send_request(OP_BYTE, 8'($urandom_range(0, 31)));
					2: begin
						do
							ch = 8'($urandom_range(32, 255));
						while (ch == CH_QUOTE || hex_char(ch));
						send_request(OP_BYTE, ch);
					end
					default: send_request(OP_END, 8'($urandom_range(0, 255)));
				endcase
			end
			default: send_request(OP_END, 8'($urandom_range(0, 255)));
		endcase
	endtask

	// one random string, mostly well formed
	task automatic send_random_string();
		logic [7:0] ch;
		int         pieces;
		int         pick;
		send_request(OP_START, 8'($urandom_range(0, 255)));
		pieces = $urandom_range(0, 10);
		for (int p = 0; p < pieces; p++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				do
					ch = 8'($urandom_range(32, 255));
				while (ch == CH_QUOTE || ch == CH_BSLASH);
				send_request(OP_BYTE, ch);
			end else if (pick < 65) begin
				send_request(OP_BYTE, CH_BSLASH);
				send_request(OP_BYTE, simple_escape($urandom_range(0, 7)));
			end else if (pick < 90) begin
				// spread code points over the one, two and three byte forms
				case ($urandom_range(0, 2))
					0:       send_unicode(16'($urandom_range(16'h0000, 16'h007F)));
					1:       send_unicode(16'($urandom_range(16'h0080, 16'h07FF)));
					default: send_unicode(16'($urandom_range(16'h0800, 16'hFFFF)));
				endcase
			end else begin
				send_broken_tail();
				return;
			end
		end
		pick = $urandom_range(0, 99);
		if (pick < 85)
			send_request(OP_BYTE, CH_QUOTE);
		else if (pick < 95)
			send_request(OP_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic run_random_until(input int goal);
		while (items_sent < goal) begin
			if ($urandom_range(0, 9) == 0)
				send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			else
				send_random_string();
		end
	endtask

	// random strings with gaps on both sides
	task automatic test_random_strings();
		src_idle_on  = 1'b1;
		snk_stall_on = 1'b1;
		run_random_until(items_sent + 130);
	endtask

	// long output hold-off while requests keep coming, so the input stalls
	task automatic test_backpressure();
		holds_asked++;
		send_request(OP_START, 8'h00);
		repeat (24)
			send_request(OP_BYTE, 8'($urandom_range(8'h30, 8'h5B)));
		send_request(OP_BYTE, CH_QUOTE);
	endtask

	// closing stretch at full rate
	task automatic test_full_rate();
		src_idle_on  = 1'b0;
		snk_stall_on = 1'b0;
		run_random_until(items_sent + 55);
	endtask

	// main sequence
	initial begin
		arst_n            <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.operation <= OP_START;
		item_ch.data_byte <= 8'h00;
		dec_mode     = MODE_IDLE;
		digits_taken = 2'd0;
		gathered_cp  = 16'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_and_close();
		test_escapes();
		test_unicode();
		test_ignored_and_restart();
		test_random_strings();
		test_backpressure();
		test_full_rate();

		// drain the outstanding results
		item_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
